// ===== design/cpbc_pkg.sv =====
// Shared types, codes and hash helper for the catalog page body checker.
package cpbc_pkg;

  localparam int unsigned MAX_BODY_BYTES_DEF = 65536;
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QIW = $clog2(QDEPTH);

  localparam logic [63:0] FNV_BASIS = 64'd1469598103934665603;
  localparam logic [63:0] MAGIC_WORD = 64'h3130_3054_4143_4253;
  localparam logic [4:0]  ROW_HDR_BYTES = 5'd20;
  localparam logic [5:0]  CKSUM_AT = 6'd40;
  localparam logic [7:0]  MIN_HDR_LEN = 8'd48;

  // configuration register indexes
  localparam logic [2:0] CFG_HDR_LEN   = 3'd0;
  localparam logic [2:0] CFG_MAJOR_MIN = 3'd1;
  localparam logic [2:0] CFG_MAJOR_MAX = 3'd2;
  localparam logic [2:0] CFG_MAJOR_CUR = 3'd3;
  localparam logic [2:0] CFG_MINOR_MAX = 3'd4;

  // record types
  localparam logic [1:0] REC_PAYLOAD = 2'd0;
  localparam logic [1:0] REC_ROW     = 2'd1;
  localparam logic [1:0] REC_END     = 2'd2;

  // page status codes
  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_SHORT     = 4'd1;
  localparam logic [3:0] ST_MAGIC     = 4'd2;
  localparam logic [3:0] ST_FORMAT    = 4'd3;
  localparam logic [3:0] ST_HDR_SIZE  = 4'd4;
  localparam logic [3:0] ST_BODY_HASH = 4'd5;
  localparam logic [3:0] ST_LENGTH    = 4'd6;
  localparam logic [3:0] ST_ROW_TRUNC = 4'd7;
  localparam logic [3:0] ST_PAY_SHORT = 4'd8;
  localparam logic [3:0] ST_PAY_HASH  = 4'd9;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HDR  = 2'd1,
    PH_PAY  = 2'd2,
    PH_DONE = 2'd3
  } phase_t;

  // everything one accepted byte produces, handed from front to back
  typedef struct packed {
    logic        has_pay;
    logic [7:0]  data;
    logic        has_row;
    logic [15:0] kind;
    logic [31:0] ordinal;
    logic [15:0] len;
    logic        ok;
    logic        has_end;
    logic [3:0]  status;
    logic [31:0] seq;
    logic [63:0] next_page;
  } event_t;

  // FNV-1a step; prime is 2^40 + 0x1b3, done as shifts and adds
  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

// ===== design/catalog_page_body_checker.sv =====
// Catalog page body checker: one body byte per transfer, validated on the fly.
// A byte is taken every cycle unless the queue is full: the front end updates the
// FNV-1a body and row hashes (shift-add multiply) and the row walk in the cycle
// the byte is accepted, and puts what that byte produces into a four-entry queue.
// The back end drains the queue through an output register, one result per cycle
// unless out_stall is high, so a byte that yields a payload byte, a row report and
// a page status makes three results. Config writes must happen while idle.
module catalog_page_body_checker #(
  parameter int unsigned MAX_BODY_BYTES = cpbc_pkg::MAX_BODY_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_body_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_record_type,
  output logic [7:0]  out_data_byte,
  output logic [15:0] out_row_kind,
  output logic [31:0] out_row_ordinal,
  output logic [15:0] out_payload_length,
  output logic        out_row_ok,
  output logic [3:0]  out_status,
  output logic [31:0] out_page_sequence,
  output logic [63:0] out_next_page,
  output logic        out_is_last
);
  import cpbc_pkg::*;

  logic acc, push, pop, q_ne, q_full;
  event_t ev_w, ev_r;

  assign in_stall = q_full;
  assign acc = in_valid && !q_full;

  cpbc_front #(.MAX_BODY_BYTES(MAX_BODY_BYTES)) u_front (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .acc(acc), .body_byte(in_body_byte), .last_byte(in_last_byte),
    .ev_push(push), .ev(ev_w)
  );

  cpbc_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(push), .wr_ev(ev_w), .pop(pop), .rd_ev(ev_r),
    .not_empty(q_ne), .full(q_full)
  );

  cpbc_back u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_ne), .q_ev(ev_r), .q_pop(pop),
    .out_stall(out_stall), .out_valid(out_valid),
    .out_record_type(out_record_type), .out_data_byte(out_data_byte),
    .out_row_kind(out_row_kind), .out_row_ordinal(out_row_ordinal),
    .out_payload_length(out_payload_length), .out_row_ok(out_row_ok),
    .out_status(out_status), .out_page_sequence(out_page_sequence),
    .out_next_page(out_next_page), .out_is_last(out_is_last)
  );

endmodule

// ===== design/cpbc_front.sv =====
// Front end: takes body bytes, tracks header, rows and hashes, builds event bundles.
module cpbc_front #(
  parameter int unsigned MAX_BODY_BYTES = cpbc_pkg::MAX_BODY_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_wdata,
  input  logic              acc,
  input  logic [7:0]        body_byte,
  input  logic              last_byte,
  output logic              ev_push,
  output cpbc_pkg::event_t  ev
);
  import cpbc_pkg::*;

  localparam int unsigned PW = $clog2(MAX_BODY_BYTES) + 1;

  logic [7:0]  hdr_len_r;
  logic [15:0] major_min_r, major_max_r, major_cur_r, minor_max_r;

  logic [PW-1:0]  pos_r, pos_nxt;
  logic [63:0]    bh_r, bh_nxt, rh_r, rh_nxt, sh_r, sh_nxt;
  logic [319:0]   hdr_r, hdr_nxt;
  logic [159:0]   rhdr_r, rhdr_nxt;
  phase_t         ph_r, ph_nxt;
  logic [31:0]    left_r, left_nxt, rows_r, rows_nxt;
  logic [2:0]     ef_r, ef_nxt; // {pay_hash, pay_short, row_trunc}

  logic [7:0]     row_start;
  logic [PW-1:0]  off;
  logic [4:0]     k;
  logic [31:0]    plen, bb, rcount;
  logic [63:0]    want;
  logic           do_begin, do_finish, row_ok;
  logic [15:0]    major, minor;
  logic [3:0]     st;

  assign row_start = (hdr_len_r < MIN_HDR_LEN) ? MIN_HDR_LEN : hdr_len_r;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_len_r   <= 8'd64;
      major_min_r <= 16'd1;
      major_max_r <= 16'd1;
      major_cur_r <= 16'd1;
      minor_max_r <= 16'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HDR_LEN:   hdr_len_r   <= cfg_wdata[7:0];
        CFG_MAJOR_MIN: major_min_r <= cfg_wdata;
        CFG_MAJOR_MAX: major_max_r <= cfg_wdata;
        CFG_MAJOR_CUR: major_cur_r <= cfg_wdata;
        CFG_MINOR_MAX: minor_max_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // page state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      bh_r   <= FNV_BASIS;
      rh_r   <= FNV_BASIS;
      sh_r   <= '0;
      hdr_r  <= '0;
      rhdr_r <= '0;
      ph_r   <= PH_IDLE;
      left_r <= '0;
      rows_r <= '0;
      ef_r   <= '0;
    end else begin
      pos_r  <= pos_nxt;
      bh_r   <= bh_nxt;
      rh_r   <= rh_nxt;
      sh_r   <= sh_nxt;
      hdr_r  <= hdr_nxt;
      rhdr_r <= rhdr_nxt;
      ph_r   <= ph_nxt;
      left_r <= left_nxt;
      rows_r <= rows_nxt;
      ef_r   <= ef_nxt;
    end
  end

  // per-byte walk, row handling and page end
  always_comb begin
    pos_nxt = pos_r; bh_nxt = bh_r; rh_nxt = rh_r; sh_nxt = sh_r;
    hdr_nxt = hdr_r; rhdr_nxt = rhdr_r; ph_nxt = ph_r; left_nxt = left_r;
    rows_nxt = rows_r; ef_nxt = ef_r;
    ev = '0;
    do_begin = 1'b0;
    do_finish = 1'b0;
    row_ok = 1'b0;
    off = pos_r + PW'(1);
    k = ROW_HDR_BYTES - left_r[4:0];
    plen = '0;
    bb = '0;
    rcount = '0;
    want = '0;
    major = '0;
    minor = '0;
    st = ST_OK;
    if (acc) begin
      if (pos_r < PW'(MAX_BODY_BYTES)) begin
        // body hash with the checksum field read as zero
        if (pos_r >= PW'(CKSUM_AT) && pos_r < PW'(CKSUM_AT + 6'd8))
          bh_nxt = fnv_step(bh_r, 8'd0);
        else
          bh_nxt = fnv_step(bh_r, body_byte);
        if (pos_r < PW'(CKSUM_AT))
          hdr_nxt[{pos_r[5:0], 3'b000} +: 8] = body_byte;
        else if (pos_r < PW'(CKSUM_AT + 6'd8))
          sh_nxt[{pos_r[2:0], 3'b000} +: 8] = body_byte;
        bb = hdr_nxt[223:192];
        rcount = hdr_nxt[191:160];

        unique case (ph_r)
          PH_HDR: begin
            rhdr_nxt[{k, 3'b000} +: 8] = body_byte;
            left_nxt = left_r - 32'd1;
            if (left_r == 32'd1) begin
              plen = rhdr_nxt[95:64];
              if (34'(off) + 34'(plen) > 34'(bb)) begin
                ef_nxt[1] = 1'b1;
                ph_nxt = PH_DONE;
              end else if (plen == 32'd0) begin
                do_finish = 1'b1;
              end else begin
                ph_nxt = PH_PAY;
                left_nxt = plen;
              end
            end
          end
          PH_PAY: begin
            ev.has_pay = 1'b1;
            ev.data = body_byte;
            rh_nxt = fnv_step(rh_r, body_byte);
            left_nxt = left_r - 32'd1;
            if (left_r == 32'd1) do_finish = 1'b1;
          end
          PH_IDLE: begin
            if (off == PW'(row_start)) do_begin = 1'b1;
          end
          default: ;
        endcase

        // row complete: report and check payload hash
        if (do_finish) begin
          want = rhdr_nxt[159:96];
          row_ok = (rh_nxt == want);
          ev.has_row = 1'b1;
          ev.kind = rhdr_nxt[15:0];
          ev.ordinal = rhdr_nxt[63:32];
          ev.len = rhdr_nxt[79:64];
          ev.ok = row_ok;
          if (!row_ok) begin
            ef_nxt[2] = 1'b1;
            ph_nxt = PH_DONE;
          end else begin
            rows_nxt = rows_r + 32'd1;
            do_begin = 1'b1;
          end
        end

        // start next row header if one is due and fits
        if (do_begin) begin
          if (rows_nxt >= rcount) begin
            ph_nxt = PH_DONE;
          end else if (34'(off) + 34'(ROW_HDR_BYTES) > 34'(bb)) begin
            ef_nxt[0] = 1'b1;
            ph_nxt = PH_DONE;
          end else begin
            ph_nxt = PH_HDR;
            left_nxt = 32'(ROW_HDR_BYTES);
            rhdr_nxt = '0;
            rh_nxt = FNV_BASIS;
          end
        end
        pos_nxt = off;
      end

      // page end status by priority, then clear page state
      if (last_byte) begin
        major = hdr_nxt[79:64];
        minor = hdr_nxt[95:80];
        bb = hdr_nxt[223:192];
        priority if (pos_nxt < PW'(row_start)) st = ST_SHORT;
        else if (hdr_nxt[63:0] != MAGIC_WORD) st = ST_MAGIC;
        else if (major < major_min_r || major > major_max_r ||
                 (major == major_cur_r && minor > minor_max_r)) st = ST_FORMAT;
        else if (hdr_nxt[127:96] != {24'd0, hdr_len_r}) st = ST_HDR_SIZE;
        else if (sh_nxt != bh_nxt) st = ST_BODY_HASH;
        else if (33'(bb) > 33'(pos_nxt) || bb < {24'd0, row_start}) st = ST_LENGTH;
        else if (ef_nxt[0]) st = ST_ROW_TRUNC;
        else if (ef_nxt[1]) st = ST_PAY_SHORT;
        else if (ef_nxt[2]) st = ST_PAY_HASH;
        else st = ST_OK;
        ev.has_end = 1'b1;
        ev.status = st;
        ev.seq = hdr_nxt[159:128];
        ev.next_page = hdr_nxt[319:256];
        pos_nxt = '0; bh_nxt = FNV_BASIS; rh_nxt = FNV_BASIS; sh_nxt = '0;
        hdr_nxt = '0; rhdr_nxt = '0; ph_nxt = PH_IDLE; left_nxt = '0;
        rows_nxt = '0; ef_nxt = '0;
      end
    end
  end

  assign ev_push = acc && (ev.has_pay || ev.has_row || ev.has_end);

endmodule

// ===== design/cpbc_queue.sv =====
// Short event queue between front and back.
module cpbc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  cpbc_pkg::event_t  wr_ev,
  input  logic              pop,
  output cpbc_pkg::event_t  rd_ev,
  output logic              not_empty,
  output logic              full
);
  import cpbc_pkg::*;

  event_t mem_r [QDEPTH];
  logic [QIW-1:0] wp_r, rp_r;
  logic [QIW:0]   cnt_r;

  assign not_empty = (cnt_r != '0);
  assign full = (cnt_r == (QIW+1)'(QDEPTH));
  assign rd_ev = mem_r[rp_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_ev;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QIW+1)'(push) - (QIW+1)'(pop);
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QIW+1)'(QDEPTH)) else $error("queue count overflow");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !not_empty |-> !pop) else $error("pop from empty queue");

endmodule

// ===== design/cpbc_back.sv =====
// Back end: splits each event bundle into result transfers through an output register.
module cpbc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  cpbc_pkg::event_t  q_ev,
  output logic              q_pop,
  input  logic              out_stall,
  output logic              out_valid,
  output logic [1:0]        out_record_type,
  output logic [7:0]        out_data_byte,
  output logic [15:0]       out_row_kind,
  output logic [31:0]       out_row_ordinal,
  output logic [15:0]       out_payload_length,
  output logic              out_row_ok,
  output logic [3:0]        out_status,
  output logic [31:0]       out_page_sequence,
  output logic [63:0]       out_next_page,
  output logic              out_is_last
);
  import cpbc_pkg::*;

  logic pay_done_r, row_done_r;
  logic valid_r;
  logic [1:0] type_r;
  logic [7:0] data_r;
  logic [15:0] kind_r, len_r;
  logic [31:0] ord_r, seq_r;
  logic ok_r, last_r;
  logic [3:0] st_r;
  logic [63:0] next_r;

  logic load, rem_pay, rem_row, sel_last;
  logic [1:0] sel_type;

  assign load = q_valid && (!valid_r || !out_stall);
  assign rem_pay = q_ev.has_pay && !pay_done_r;
  assign rem_row = q_ev.has_row && !row_done_r;

  // pick the earliest pending record of the head bundle
  always_comb begin
    priority if (rem_pay) begin
      sel_type = REC_PAYLOAD;
      sel_last = !(q_ev.has_row || q_ev.has_end);
    end else if (rem_row) begin
      sel_type = REC_ROW;
      sel_last = !q_ev.has_end;
    end else begin
      sel_type = REC_END;
      sel_last = 1'b1;
    end
  end

  assign q_pop = load && sel_last;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pay_done_r <= 1'b0;
      row_done_r <= 1'b0;
    end else begin
      if (load) valid_r <= 1'b1;
      else if (!out_stall) valid_r <= 1'b0;
      if (q_pop) begin
        pay_done_r <= 1'b0;
        row_done_r <= 1'b0;
      end else if (load) begin
        if (sel_type == REC_PAYLOAD) pay_done_r <= 1'b1;
        if (sel_type == REC_ROW) row_done_r <= 1'b1;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      type_r <= sel_type;
      last_r <= sel_last;
      data_r <= (sel_type == REC_PAYLOAD) ? q_ev.data : 8'd0;
      kind_r <= (sel_type == REC_ROW) ? q_ev.kind : 16'd0;
      ord_r  <= (sel_type == REC_ROW) ? q_ev.ordinal : 32'd0;
      len_r  <= (sel_type == REC_ROW) ? q_ev.len : 16'd0;
      ok_r   <= (sel_type == REC_ROW) ? q_ev.ok : 1'b0;
      st_r   <= (sel_type == REC_END) ? q_ev.status : 4'd0;
      seq_r  <= (sel_type == REC_END) ? q_ev.seq : 32'd0;
      next_r <= (sel_type == REC_END) ? q_ev.next_page : 64'd0;
    end
  end

  assign out_valid = valid_r;
  assign out_record_type = type_r;
  assign out_data_byte = data_r;
  assign out_row_kind = kind_r;
  assign out_row_ordinal = ord_r;
  assign out_payload_length = len_r;
  assign out_row_ok = ok_r;
  assign out_status = st_r;
  assign out_page_sequence = seq_r;
  assign out_next_page = next_r;
  assign out_is_last = last_r;

endmodule

// ===== verif/catalog_page_body_checker_scoreboard.sv =====
// Scoreboard for the catalog page body checker: predicts every result and compares.
`timescale 1ns / 1ps
module catalog_page_body_checker_scoreboard
  import cpbc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_body_byte,
  input  logic        in_last_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_record_type,
  input  logic [7:0]  out_data_byte,
  input  logic [15:0] out_row_kind,
  input  logic [31:0] out_row_ordinal,
  input  logic [15:0] out_payload_length,
  input  logic        out_row_ok,
  input  logic [3:0]  out_status,
  input  logic [31:0] out_page_sequence,
  input  logic [63:0] out_next_page,
  input  logic        out_is_last,
  output int          fail_count,
  output int          pending,
  output int          rows_seen,
  output int          pages_seen
);

  localparam int unsigned BODY_LIMIT = 65536;
  localparam logic [63:0] HASH_MUL = 64'd1099511628211;

  typedef struct packed {
    logic [1:0]  rtype;
    logic [7:0]  data;
    logic [15:0] kind;
    logic [31:0] ordinal;
    logic [15:0] len;
    logic        ok;
    logic [3:0]  status;
    logic [31:0] seq;
    logic [63:0] next_page;
    logic        last;
  } page_result_t;

  page_result_t result_q[$];

  // register copies
  logic [7:0]  hdr_len_r;
  logic [15:0] maj_min_r, maj_max_r, maj_cur_r, min_max_r;

  // page walk state
  int unsigned pos;
  logic [63:0] body_h, row_h, stored_h;
  logic [63:0] hdr_w[5];
  logic [63:0] row_w[3];
  phase_t      phase;
  int unsigned left_cnt;
  logic [31:0] row_cnt_done;
  logic        err_hdr_trunc, err_pay_short, err_pay_hash;

  assign pending = result_q.size();

  function automatic int unsigned first_row_at();
    return (hdr_len_r < MIN_HDR_LEN) ? 48 : hdr_len_r;
  endfunction

  task automatic clear_page();
    pos = 0;
    body_h = FNV_BASIS;
    row_h = FNV_BASIS;
    stored_h = '0;
    foreach (hdr_w[i]) hdr_w[i] = '0;
    foreach (row_w[i]) row_w[i] = '0;
    phase = PH_IDLE;
    left_cnt = 0;
    row_cnt_done = '0;
    err_hdr_trunc = 1'b0;
    err_pay_short = 1'b0;
    err_pay_hash = 1'b0;
  endtask

  task automatic push_result(input logic [1:0] rt, input logic [7:0] d, input logic [15:0] k,
                             input logic [31:0] o, input logic [15:0] l, input logic ok,
                             input logic [3:0] st, input logic [31:0] sq, input logic [63:0] np);
    page_result_t r;
    r = '{rtype: rt, data: d, kind: k, ordinal: o, len: l, ok: ok, status: st, seq: sq,
          next_page: np, last: 1'b0};
    result_q = {result_q, r};
  endtask

  task automatic open_row(input longint unsigned off);
    if (row_cnt_done >= hdr_w[2][63:32]) begin
      phase = PH_DONE;
    end else if (off + 20 > hdr_w[3][31:0]) begin
      err_hdr_trunc = 1'b1;
      phase = PH_DONE;
    end else begin
      phase = PH_HDR;
      left_cnt = 20;
      foreach (row_w[i]) row_w[i] = '0;
      row_h = FNV_BASIS;
    end
  endtask

  task automatic close_row(input longint unsigned off);
    logic [63:0] want;
    logic ok;
    want = (row_w[1] >> 32) | (row_w[2] << 32);
    ok = (row_h == want);
    push_result(REC_ROW, 8'd0, row_w[0][15:0], row_w[0][63:32], row_w[1][15:0], ok,
                ST_OK, 32'd0, 64'd0);
    if (!ok) begin
      err_pay_hash = 1'b1;
      phase = PH_DONE;
    end else begin
      row_cnt_done++;
      open_row(off);
    end
  endtask

  task automatic row_header_done(input longint unsigned off);
    longint unsigned plen;
    plen = row_w[1][31:0];
    if (off + plen > hdr_w[3][31:0]) begin
      err_pay_short = 1'b1;
      phase = PH_DONE;
    end else if (plen == 0) begin
      close_row(off);
    end else begin
      phase = PH_PAY;
      left_cnt = plen;
    end
  endtask

  // status by fixed priority
  function automatic logic [3:0] page_verdict();
    logic [15:0] major, minor;
    longint unsigned bb;
    major = hdr_w[1][15:0];
    minor = hdr_w[1][31:16];
    bb = hdr_w[3][31:0];
    if (pos < first_row_at()) return ST_SHORT;
    if (hdr_w[0] != MAGIC_WORD) return ST_MAGIC;
    if (major < maj_min_r || major > maj_max_r || (major == maj_cur_r && minor > min_max_r))
      return ST_FORMAT;
    if (hdr_w[1][63:32] != {24'd0, hdr_len_r}) return ST_HDR_SIZE;
    if (stored_h != body_h) return ST_BODY_HASH;
    if (bb > pos || bb < first_row_at()) return ST_LENGTH;
    if (err_hdr_trunc) return ST_ROW_TRUNC;
    if (err_pay_short) return ST_PAY_SHORT;
    if (err_pay_hash) return ST_PAY_HASH;
    return ST_OK;
  endfunction

  // one accepted body byte
  task automatic take_body_byte(input logic [7:0] b, input logic last);
    int unsigned p, k, n0;
    logic [7:0] hb;
    n0 = result_q.size();
    if (pos < BODY_LIMIT) begin
      p = pos;
      hb = (p >= 40 && p < 48) ? 8'd0 : b;
      body_h = (body_h ^ {56'd0, hb}) * HASH_MUL;
      if (p < 40) hdr_w[p >> 3] |= {56'd0, b} << ((p & 7) * 8);
      else if (p < 48) stored_h |= {56'd0, b} << ((p & 7) * 8);
      if (phase == PH_HDR) begin
        k = 20 - left_cnt;
        row_w[k >> 3] |= {56'd0, b} << ((k & 7) * 8);
        left_cnt--;
        if (left_cnt == 0) row_header_done(p + 1);
      end else if (phase == PH_PAY) begin
        push_result(REC_PAYLOAD, b, 16'd0, 32'd0, 16'd0, 1'b0, ST_OK, 32'd0, 64'd0);
        row_h = (row_h ^ {56'd0, b}) * HASH_MUL;
        left_cnt--;
        if (left_cnt == 0) close_row(p + 1);
      end else if (phase == PH_IDLE && p + 1 == first_row_at()) begin
        open_row(p + 1);
      end
      pos = p + 1;
    end
    if (last) begin
      push_result(REC_END, 8'd0, 16'd0, 32'd0, 16'd0, 1'b0, page_verdict(), hdr_w[2][31:0],
                  hdr_w[4]);
      clear_page();
    end
    if (result_q.size() > n0) result_q[result_q.size() - 1].last = 1'b1;
  endtask

  // watch config writes, input transfers and result transfers
  always @(posedge clk) begin
    page_result_t e, a;
    if (!rst_n) begin
      hdr_len_r = 8'd64;
      maj_min_r = 16'd1;
      maj_max_r = 16'd1;
      maj_cur_r = 16'd1;
      min_max_r = 16'd0;
      clear_page();
      result_q.delete();
      fail_count = 0;
      rows_seen = 0;
      pages_seen = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_HDR_LEN:   hdr_len_r = cfg_wdata[7:0];
          CFG_MAJOR_MIN: maj_min_r = cfg_wdata;
          CFG_MAJOR_MAX: maj_max_r = cfg_wdata;
          CFG_MAJOR_CUR: maj_cur_r = cfg_wdata;
          CFG_MINOR_MAX: min_max_r = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) take_body_byte(in_body_byte, in_last_byte);
      if (out_valid && !out_stall) begin
        a = '{rtype: out_record_type, data: out_data_byte, kind: out_row_kind,
              ordinal: out_row_ordinal, len: out_payload_length, ok: out_row_ok,
              status: out_status, seq: out_page_sequence, next_page: out_next_page,
              last: out_is_last};
        if (out_record_type == REC_ROW) rows_seen++;
        if (out_record_type == REC_END) pages_seen++;
        if (result_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result transfer: %h", $time, a);
        end else begin
          e = result_q.pop_front();
          if (a != e) begin
            fail_count++;
            $display("%0t: mismatch type/data/kind/ord/len/ok/st/seq/next/last", $time);
            $display("  expected %0d %h %h %h %h %b %0d %h %h %b", e.rtype, e.data, e.kind,
                     e.ordinal, e.len, e.ok, e.status, e.seq, e.next_page, e.last);
            $display("  actual   %0d %h %h %h %h %b %0d %h %h %b", a.rtype, a.data, a.kind,
                     a.ordinal, a.len, a.ok, a.status, a.seq, a.next_page, a.last);
          end
        end
      end
    end
  end

endmodule

// ===== verif/catalog_page_body_checker_tb.sv =====
// Top of the catalog page body checker testbench: clock, reset, page stimulus, verdict.
`timescale 1ns / 1ps
module catalog_page_body_checker_tb;
  import cpbc_pkg::*;

  localparam logic [63:0] HASH_MUL = 64'd1099511628211;
  localparam int unsigned CYCLE_LIMIT = 50000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_wdata;
  logic        in_valid, in_stall;
  logic [7:0]  in_body_byte;
  logic        in_last_byte;
  logic        out_valid, out_stall;
  logic [1:0]  out_record_type;
  logic [7:0]  out_data_byte;
  logic [15:0] out_row_kind;
  logic [31:0] out_row_ordinal;
  logic [15:0] out_payload_length;
  logic        out_row_ok;
  logic [3:0]  out_status;
  logic [31:0] out_page_sequence;
  logic [63:0] out_next_page;
  logic        out_is_last;

  int fail_count, pending, rows_seen, pages_seen;
  int idle_mode;
  int send_pct, recv_pct;
  int bytes_sent;
  longint unsigned cycles;

  // tb copies of the registers, used to shape pages
  logic [7:0]  hl_set;
  logic [15:0] mmin_set, mmax_set, mcur_set, nmax_set;

  catalog_page_body_checker dut (.*);

  catalog_page_body_checker_scoreboard sb (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // cycle budget
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("catalog_page_body_checker verification failed");
      $finish;
    end
  end

  // receiver stalls, with one long hold-off when the no-idle phase starts
  always @(posedge clk) begin
    int hold;
    bit pressure_done;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold > 0) begin
      out_stall <= 1'b1;
      hold--;
    end else if (idle_mode == 2 && !pressure_done) begin
      pressure_done = 1'b1;
      hold = 400;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_pct);
    end
  end

  function automatic logic [63:0] fnv64(input logic [63:0] h, input logic [7:0] b);
    return (h ^ {56'd0, b}) * HASH_MUL;
  endfunction

  task automatic put_le(ref logic [7:0] q[$], input int off, input logic [63:0] v,
                        input int n);
    for (int i = 0; i < n; i++) q[off + i] = v[8 * i +: 8];
  endtask

  // one byte transfer with random sender gaps
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_body_byte <= b;
    in_last_byte <= last;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  // valid stays up after the last byte; the next send or an explicit drop replaces it
  task automatic send_page(ref logic [7:0] q[$]);
    foreach (q[i]) send_byte(q[i], i == q.size() - 1);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [7:0] hl, input logic [15:0] mn, mx, cur, nm);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    write_reg(CFG_HDR_LEN, {8'd0, hl});
    write_reg(CFG_MAJOR_MIN, mn);
    write_reg(CFG_MAJOR_MAX, mx);
    write_reg(CFG_MAJOR_CUR, cur);
    write_reg(CFG_MINOR_MAX, nm);
    cfg_we <= 1'b0;
    hl_set = hl;
    mmin_set = mn;
    mmax_set = mx;
    mcur_set = cur;
    nmax_set = nm;
  endtask

  // build one page; flaw 0 is a clean page, others damage one aspect
  task automatic build_page(ref logic [7:0] q[$], input int flaw);
    int start, nrows, off, plen, body_len;
    int row_at[$];
    logic [15:0] major, minor;
    logic [63:0] h;
    q.delete();
    start = (hl_set < MIN_HDR_LEN) ? 48 : hl_set;
    for (int i = 0; i < start; i++) q = {q, 8'($urandom_range(0, 255))};
    nrows = $urandom_range(0, 3);
    for (int r = 0; r < nrows; r++) begin
      off = q.size();
      row_at = {row_at, off};
      plen = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 8);
      for (int i = 0; i < 20 + plen; i++) q = {q, 8'($urandom_range(0, 255))};
      h = FNV_BASIS;
      for (int i = 0; i < plen; i++) h = fnv64(h, q[off + 20 + i]);
      put_le(q, off + 8, plen, 4);
      put_le(q, off + 12, h, 8);
    end
    repeat ($urandom_range(0, 3)) q = {q, 8'($urandom_range(0, 255))};
    body_len = q.size();
    major = $urandom_range(mmin_set, mmax_set);
    minor = (major == mcur_set) ? $urandom_range(0, nmax_set) : $urandom_range(0, 65535);
    put_le(q, 0, MAGIC_WORD, 8);
    put_le(q, 8, major, 2);
    put_le(q, 10, minor, 2);
    put_le(q, 12, hl_set, 4);
    put_le(q, 20, nrows, 4);
    put_le(q, 24, body_len, 4);
    case (flaw)
      1: q[$urandom_range(0, 7)] ^= 8'd1 << $urandom_range(0, 7);
      2: put_le(q, 8, {$urandom, $urandom}, 4);
      3: put_le(q, 12, $urandom_range(0, 300), 4);
      5: put_le(q, 24, $urandom_range(0, body_len + 30), 4);
      6: if (nrows > 0) q[row_at[0] + 12] ^= 8'h80;
      8: repeat ($urandom_range(1, 5)) q = {q, 8'($urandom_range(0, 255))};
      9: if (nrows > 0) put_le(q, row_at[0] + 8, 32'hFFFF_FFF0 | $urandom_range(0, 15), 4);
      10: put_le(q, 20, nrows + $urandom_range(1, 3), 4);
      11: put_le(q, 20, $urandom, 4);
      default: ;
    endcase
    h = FNV_BASIS;
    foreach (q[i]) h = fnv64(h, (i >= 40 && i < 48) ? 8'd0 : q[i]);
    put_le(q, 40, h, 8);
    case (flaw)
      4: q[40 + $urandom_range(0, 7)] ^= 8'd1 << $urandom_range(0, 7);
      7: q = q[0 : $urandom_range(0, q.size() - 2)];
      default: ;
    endcase
  endtask

  // random pages until the byte budget of this phase is spent
  task automatic random_pages(input int budget);
    logic [7:0] pg[$];
    int goal;
    goal = bytes_sent + budget;
    while (bytes_sent < goal) begin
      if ($urandom_range(0, 9) < 2) begin
        pg.delete();
        repeat ($urandom_range(1, 60)) pg = {pg, 8'($urandom_range(0, 255))};
      end else begin
        build_page(pg, ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 11));
      end
      send_page(pg);
    end
  endtask

  task automatic set_idle(input int mode);
    idle_mode = mode;
    send_pct = (mode == 0) ? 33 : (mode == 1) ? 72 : 0;
    recv_pct = (mode == 0) ? 72 : (mode == 1) ? 33 : 0;
  endtask

  initial begin
    logic [7:0] pg[$];
    cycles = 0;
    bytes_sent = 0;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_HDR_LEN;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_body_byte <= '0;
    in_last_byte <= 1'b0;
    hl_set = 8'd64;
    mmin_set = 16'd1;
    mmax_set = 16'd1;
    mcur_set = 16'd1;
    nmax_set = 16'd0;
    set_idle(0);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: one-byte pages at both byte extremes, then a short page
    pg = '{8'h00};
    send_page(pg);
    pg = '{8'hFF};
    send_page(pg);
    pg = '{8'h53, 8'h42, 8'h43, 8'h41, 8'h54, 8'h30, 8'h30, 8'h31, 8'h01, 8'h00};
    send_page(pg);

    // register settings, reset values first, then the extremes and a mixed set
    apply_settings(8'd64, 16'd1, 16'd1, 16'd1, 16'd0);
    random_pages(1);
    set_idle(1);
    apply_settings(8'd48, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
    random_pages(40);
    set_idle(2);
    // burst of one-byte pages while the receiver holds off, so the queue fills
    repeat (8) begin
      pg = '{8'($urandom_range(0, 255))};
      send_page(pg);
    end
    apply_settings(8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
    random_pages(1);
    apply_settings(8'd10, 16'd5, 16'd9, 16'd7, 16'd3);
    random_pages(1);

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d body bytes in clean and damaged pages under four register settings;",
             bytes_sent);
    $display("checked %0d page ends and %0d row reports.", pages_seen, rows_seen);
    if (fail_count == 0) begin
      $display("catalog_page_body_checker verification clean");
    end else begin
      $display("catalog_page_body_checker verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/cpbc_pkg.sv
design/cpbc_front.sv
design/cpbc_queue.sv
design/cpbc_back.sv
design/catalog_page_body_checker.sv
verif/catalog_page_body_checker_scoreboard.sv
verif/catalog_page_body_checker_tb.sv
